// File: sv/dre_pkg.sv
`timescale 1ns / 1ps

package dre_pkg;

    localparam int SUM_W   = 48;
    localparam int VAL_W   = 32;
    localparam int RATIO_W = 24;
    localparam int WIN_W   = 32;
    localparam int FACT_W  = 33;

    // Serial divider geometry: 48-bit divisor, 32 quotient bits per run.
    localparam int DIV_RW = 48;
    localparam int DIV_QW = 32;

    localparam logic [SUM_W-1:0]   SUM_MAX      = {SUM_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_MAX    = {RATIO_W{1'b1}};
    localparam logic [VAL_W-1:0]   AVG_RESET    = 32'd838861;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = 32'd1000000;
    localparam logic [SUM_W-1:0]   MIN_DT       = 48'd1000;
    localparam int                 DECAY_SPAN   = 16;
    localparam int                 DECAY_SPAN_SHIFT = 4;
    localparam int                 TAYLOR_TERMS = 12;
    localparam logic [4:0]         AVG_WEIGHT   = 5'd19;
    localparam logic [4:0]         AVG_ROUND    = 5'd10;

    // The average is divided by 20 as a shift by two followed by a division by 5.
    // floor(2^32 / 5) folds the upper word, and ceil(2^35 / 5) is exact for 33-bit inputs.
    localparam logic [VAL_W-1:0]   AVG_WORD_DIV5    = 32'd858993459;
    localparam logic [FACT_W-1:0]  AVG_RECIP5       = 33'd6871947674;
    localparam int                 AVG_RECIP5_SHIFT = 35;

    localparam logic REG_WINDOW_TICKS = 1'b0;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_PREP,
        OP_CLEAR_SUMS,
        OP_DIV_DECAY,
        OP_TABLE,
        OP_FACTOR,
        OP_PS_HI,
        OP_PS_LO,
        OP_CS_HI,
        OP_CS_LO,
        OP_ADD,
        OP_DIV_AVG,
        OP_AVG,
        OP_RATIO_ZERO,
        OP_RATIO_SAT,
        OP_DIV_RATIO,
        OP_RATIO,
        OP_SMOOTH_COPY,
        OP_DIV_ALPHA,
        OP_SM1,
        OP_SM2,
        OP_FINISH
    } op_t;

    typedef struct packed {
        logic decay_en;
        logic long_gap;
        logic delta_nz;
        logic applied;
        logic ps_zero;
        logic ratio_sat;
        logic smooth_direct;
        logic div_busy;
    } status_t;

    // Per-step decay factor exp(-span/N) in Q0.32 from a truncated Taylor series.
    function automatic logic [63:0] decay_step(logic [63:0] a);
        logic [63:0] term;
        logic [63:0] r;
        term = 64'h1_0000_0000;
        r    = 64'h1_0000_0000;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * a) >> 32) / 64'(n);
            if ((n % 2) == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] decay_entry(int unsigned k, logic [63:0] r);
        logic [63:0] e;
        e = 64'h1_0000_0000;
        for (int unsigned i = 0; i < k; i++) begin
            e = (e * r + 64'h8000_0000) >> 32;
        end
        return e;
    endfunction

endpackage

// File: sv/dre_div.sv
`timescale 1ns / 1ps

module dre_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dre_pkg::DIV_RW-1:0]  rem_init,
    input  logic [dre_pkg::DIV_QW-1:0]  num_low,
    input  logic [dre_pkg::DIV_RW-1:0]  den,
    output logic                        busy,
    output logic [dre_pkg::DIV_QW-1:0]  quot
);
    import dre_pkg::*;

    localparam int CNT_W = $clog2(DIV_QW + 1);

    logic [DIV_RW-1:0] rem_reg, rem_next;
    logic [DIV_QW-1:0] shf_reg, shf_next;
    logic [DIV_RW-1:0] den_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DIV_RW:0]   rem_sh;
    logic [DIV_RW:0]   rem_sub;

    // Restoring division: one quotient bit per cycle, quotient bits replace dividend bits.
    always_comb begin
        rem_sh    = {rem_reg, shf_reg[DIV_QW-1]};
        rem_sub   = rem_sh - {1'b0, den_reg};
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = rem_init;
            shf_next  = num_low;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!rem_sub[DIV_RW]) begin
                rem_next = rem_sub[DIV_RW-1:0];
                shf_next = {shf_reg[DIV_QW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIV_RW-1:0];
                shf_next = {shf_reg[DIV_QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIV_QW - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign quot = shf_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> cnt_reg == CNT_W'(DIV_QW)) else $error("divider run length wrong");

endmodule

// File: sv/dre_datapath.sv
`timescale 1ns / 1ps

module dre_datapath #(
    parameter int DECAY_TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dre_pkg::op_t                  op,
    output dre_pkg::status_t              status,
    input  logic                          win_wr,
    input  logic [dre_pkg::WIN_W-1:0]     win_data,
    output logic [dre_pkg::WIN_W-1:0]     win_value,
    input  logic [dre_pkg::SUM_W-1:0]     timestamp,
    input  logic [dre_pkg::VAL_W-1:0]     value_before,
    input  logic [dre_pkg::VAL_W-1:0]     value_after,
    input  logic                          constraint_applied,
    output logic [dre_pkg::RATIO_W-1:0]   ratio_raw,
    output logic [dre_pkg::RATIO_W-1:0]   ratio_smoothed
);
    import dre_pkg::*;

    localparam int N     = DECAY_TABLE_ENTRIES;
    localparam int IW    = $clog2(N + 1);
    localparam int LOGN  = $clog2(N);
    localparam int QPW   = SUM_W + IW;
    localparam logic [63:0] DECAY_A = (64'(DECAY_SPAN) << 32) / 64'(DECAY_TABLE_ENTRIES);
    localparam logic [63:0] DECAY_R = decay_step(DECAY_A);

    logic [FACT_W-1:0] rom [N+1];

    for (genvar g = 0; g <= N; g++) begin : g_rom
        assign rom[g] = FACT_W'(decay_entry(g, DECAY_R));
    end

    logic [WIN_W-1:0]   win_reg;
    logic [SUM_W-1:0]   ps_reg, cs_reg, prev_reg;
    logic [VAL_W-1:0]   avg_reg;
    logic               seen_reg;
    logic [RATIO_W-1:0] sm_reg;

    logic [SUM_W-1:0]   ts_reg;
    logic [VAL_W-1:0]   delta_reg;
    logic               applied_reg;
    logic [QPW-1:0]     q_reg;
    logic [FACT_W-1:0]  t0_reg, t1_reg, f_reg;
    logic [15:0]        frac_reg;
    logic [65:0]        acc_reg;
    logic [36:0]        avgnum_reg;
    logic [VAL_W:0]     avgz_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [RATIO_W-1:0] out_raw_reg, out_sm_reg;

    logic [WIN_W-1:0]   win_eff;
    logic [SUM_W-1:0]   dt, dt_c;
    logic [SUM_W-1:0]   den16;
    logic               ts_gt;
    logic [FACT_W-1:0]  mul_a, mul_b;
    logic [65:0]        mul_p;
    logic [VAL_W-1:0]   part;
    logic [SUM_W:0]     ps_add, cs_add;
    logic [IW-1:0]      tab_idx;
    logic [FACT_W-1:0]  alpha_c;

    logic               div_start;
    logic [DIV_RW-1:0]  div_rem, div_den;
    logic [DIV_QW-1:0]  div_low, div_quot;
    logic               div_busy;

    dre_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .rem_init (div_rem),
        .num_low  (div_low),
        .den      (div_den),
        .busy     (div_busy),
        .quot     (div_quot)
    );

    always_comb begin
        win_eff = (win_reg == '0) ? WIN_W'(1) : win_reg;
        dt      = ts_reg - prev_reg;
        ts_gt   = ts_reg > prev_reg;
        den16   = SUM_W'(win_eff) << DECAY_SPAN_SHIFT;
        dt_c    = (dt < MIN_DT) ? MIN_DT : dt;
        tab_idx = IW'(div_quot[16+LOGN-1:16]);
        alpha_c = {1'b0, div_quot};
        part    = (delta_reg < avg_reg) ? delta_reg : avg_reg;
        ps_add  = {1'b0, ps_reg} + (applied_reg ? (SUM_W+1)'(part) : (SUM_W+1)'(delta_reg));
        cs_add  = {1'b0, cs_reg} + (SUM_W+1)'(delta_reg - part);

        status.decay_en      = seen_reg && ts_gt;
        status.long_gap      = dt >= den16;
        status.delta_nz      = delta_reg != '0;
        status.applied       = applied_reg;
        status.ps_zero       = ps_reg == '0;
        status.ratio_sat     = {8'b0, cs_reg} >= {ps_reg, 8'b0};
        status.smooth_direct = (prev_reg == '0) || !ts_gt || (dt_c >= SUM_W'(win_eff));
        status.div_busy      = div_busy;

        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_FACTOR: begin
                mul_a = t0_reg - t1_reg;
                mul_b = FACT_W'(frac_reg);
            end
            OP_PS_HI: begin
                mul_a = FACT_W'(ps_reg[47:24]);
                mul_b = f_reg;
            end
            OP_PS_LO: begin
                mul_a = FACT_W'(ps_reg[23:0]);
                mul_b = f_reg;
            end
            OP_CS_HI: begin
                mul_a = FACT_W'(cs_reg[47:24]);
                mul_b = f_reg;
            end
            OP_CS_LO: begin
                mul_a = FACT_W'(cs_reg[23:0]);
                mul_b = f_reg;
            end
            OP_AVG: begin
                mul_a = avgz_reg;
                mul_b = AVG_RECIP5;
            end
            OP_SM1: begin
                mul_a = FACT_W'(sm_reg);
                mul_b = {1'b1, 32'h0} - alpha_c;
            end
            OP_SM2: begin
                mul_a = FACT_W'(ratio_reg);
                mul_b = alpha_c;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 66'(mul_a) * 66'(mul_b);

        div_start = 1'b0;
        div_rem   = '0;
        div_low   = '0;
        div_den   = '0;
        case (op)
            OP_DIV_DECAY: begin
                div_start = 1'b1;
                div_rem   = DIV_RW'(q_reg >> 16);
                div_low   = {q_reg[15:0], 16'h0000};
                div_den   = den16;
            end
            OP_DIV_RATIO: begin
                div_start = 1'b1;
                div_rem   = DIV_RW'(cs_reg[47:16]);
                div_low   = {cs_reg[15:0], 16'h0000};
                div_den   = ps_reg;
            end
            OP_DIV_ALPHA: begin
                div_start = 1'b1;
                div_rem   = dt_c;
                div_low   = '0;
                div_den   = DIV_RW'(win_eff);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Architectural state.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win_reg  <= WINDOW_RESET;
            ps_reg   <= '0;
            cs_reg   <= '0;
            avg_reg  <= AVG_RESET;
            prev_reg <= '0;
            seen_reg <= 1'b0;
            sm_reg   <= '0;
        end else begin
            if (win_wr) begin
                win_reg <= win_data;
            end
            case (op)
                OP_CLEAR_SUMS: begin
                    ps_reg <= '0;
                    cs_reg <= '0;
                end
                OP_PS_LO: begin
                    ps_reg <= SUM_W'((acc_reg + (mul_p >> 24)) >> 8);
                end
                OP_CS_LO: begin
                    cs_reg <= SUM_W'((acc_reg + (mul_p >> 24)) >> 8);
                end
                OP_ADD: begin
                    if (delta_reg != '0) begin
                        ps_reg <= ps_add[SUM_W] ? SUM_MAX : ps_add[SUM_W-1:0];
                        if (applied_reg) begin
                            cs_reg <= cs_add[SUM_W] ? SUM_MAX : cs_add[SUM_W-1:0];
                        end
                    end
                end
                OP_AVG: begin
                    avg_reg <= VAL_W'(avgnum_reg[36:34]) * AVG_WORD_DIV5
                               + VAL_W'(mul_p >> AVG_RECIP5_SHIFT);
                end
                OP_SMOOTH_COPY: begin
                    sm_reg <= ratio_reg;
                end
                OP_SM2: begin
                    sm_reg <= RATIO_W'((acc_reg + mul_p + 66'h8000_0000) >> 32);
                end
                OP_FINISH: begin
                    prev_reg <= ts_reg;
                    seen_reg <= 1'b1;
                end
                default: begin
                    seen_reg <= seen_reg;
                end
            endcase
        end
    end

    // Working registers for the item in flight.
    always_ff @(posedge clk) begin
        case (op)
            OP_CAPTURE: begin
                ts_reg      <= timestamp;
                delta_reg   <= (value_after >= value_before) ? value_after - value_before
                                                             : value_before - value_after;
                applied_reg <= constraint_applied;
            end
            OP_PREP: begin
                q_reg <= QPW'(dt) * QPW'(N);
            end
            OP_TABLE: begin
                t0_reg   <= rom[tab_idx];
                t1_reg   <= rom[tab_idx + IW'(1)];
                frac_reg <= div_quot[15:0];
            end
            OP_FACTOR: begin
                f_reg <= t0_reg - FACT_W'(mul_p >> 16);
            end
            OP_PS_HI, OP_CS_HI, OP_SM1: begin
                acc_reg <= mul_p;
            end
            OP_ADD: begin
                avgnum_reg <= 37'(avg_reg) * 37'(AVG_WEIGHT) + 37'(delta_reg) + 37'(AVG_ROUND);
            end
            OP_DIV_AVG: begin
                // The upper word of numerator/4 is folded in, since 2^32 is 1 more than 5k.
                avgz_reg <= (VAL_W+1)'(avgnum_reg[36:34]) + (VAL_W+1)'(avgnum_reg[33:2]);
            end
            OP_RATIO_ZERO: begin
                ratio_reg <= '0;
            end
            OP_RATIO_SAT: begin
                ratio_reg <= RATIO_MAX;
            end
            OP_RATIO: begin
                ratio_reg <= div_quot[RATIO_W-1:0];
            end
            OP_FINISH: begin
                out_raw_reg <= ratio_reg;
                out_sm_reg  <= sm_reg;
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign win_value      = win_reg;
    assign ratio_raw      = out_raw_reg;
    assign ratio_smoothed = out_sm_reg;

endmodule

// File: sv/dre_ctrl.sv
`timescale 1ns / 1ps

module dre_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dre_pkg::status_t  status,
    output dre_pkg::op_t      op
);
    import dre_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_D1, S_D1W, S_TAB, S_FAC, S_PH, S_PL, S_CH, S_CL,
        S_ADD, S_DA, S_AVG, S_RAT, S_DR, S_DRW, S_RQ, S_SMO, S_DS, S_DSW,
        S_SM1, S_SM2, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        op         = OP_NOP;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op         = OP_CAPTURE;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                if (!status.decay_en) begin
                    state_next = S_ADD;
                end else if (status.long_gap) begin
                    op         = OP_CLEAR_SUMS;
                    state_next = S_ADD;
                end else begin
                    op         = OP_PREP;
                    state_next = S_D1;
                end
            end
            S_D1: begin
                op         = OP_DIV_DECAY;
                state_next = S_D1W;
            end
            S_D1W: begin
                if (!status.div_busy) begin
                    state_next = S_TAB;
                end
            end
            S_TAB: begin
                op         = OP_TABLE;
                state_next = S_FAC;
            end
            S_FAC: begin
                op         = OP_FACTOR;
                state_next = S_PH;
            end
            S_PH: begin
                op         = OP_PS_HI;
                state_next = S_PL;
            end
            S_PL: begin
                op         = OP_PS_LO;
                state_next = S_CH;
            end
            S_CH: begin
                op         = OP_CS_HI;
                state_next = S_CL;
            end
            S_CL: begin
                op         = OP_CS_LO;
                state_next = S_ADD;
            end
            S_ADD: begin
                op         = OP_ADD;
                state_next = (status.delta_nz && !status.applied) ? S_DA : S_RAT;
            end
            S_DA: begin
                op         = OP_DIV_AVG;
                state_next = S_AVG;
            end
            S_AVG: begin
                op         = OP_AVG;
                state_next = S_RAT;
            end
            S_RAT: begin
                if (status.ps_zero) begin
                    op         = OP_RATIO_ZERO;
                    state_next = S_SMO;
                end else if (status.ratio_sat) begin
                    op         = OP_RATIO_SAT;
                    state_next = S_SMO;
                end else begin
                    state_next = S_DR;
                end
            end
            S_DR: begin
                op         = OP_DIV_RATIO;
                state_next = S_DRW;
            end
            S_DRW: begin
                if (!status.div_busy) begin
                    state_next = S_RQ;
                end
            end
            S_RQ: begin
                op         = OP_RATIO;
                state_next = S_SMO;
            end
            S_SMO: begin
                if (status.smooth_direct) begin
                    op         = OP_SMOOTH_COPY;
                    state_next = S_DONE;
                end else begin
                    state_next = S_DS;
                end
            end
            S_DS: begin
                op         = OP_DIV_ALPHA;
                state_next = S_DSW;
            end
            S_DSW: begin
                if (!status.div_busy) begin
                    state_next = S_SM1;
                end
            end
            S_SM1: begin
                op         = OP_SM1;
                state_next = S_SM2;
            end
            S_SM2: begin
                op         = OP_SM2;
                state_next = S_DONE;
            end
            S_DONE: begin
                // Wait for the output register to free up before committing.
                if (!out_valid_reg || out_ready) begin
                    op         = OP_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (op == OP_FINISH) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_PREP) else $error("accept did not start work");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |-> !out_valid_reg || out_ready) else $error("result overwritten");
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DIV_DECAY || op == OP_DIV_RATIO || op == OP_DIV_ALPHA)
        |-> !status.div_busy) else $error("division issued while divider busy");
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        op == OP_FINISH |=> out_valid_reg) else $error("finished result not presented");

endmodule

// File: sv/decayed_ratio_estimator.sv
`timescale 1ns / 1ps

// Decayed ratio estimator.
// Input channel (in_valid/in_ready) takes one transaction per sample: timestamp,
// value_before, value_after and constraint_applied. Output channel (out_valid/out_ready)
// returns one transaction per sample with ratio_raw and ratio_smoothed, both Q8.16.
// The APB port holds window_ticks at address 0; write it only while the block is idle.
// One sample is processed at a time by a sequencer driving a shared multiplier and a
// radix-2 serial divider that yields 32 quotient bits per run. A sample that needs no
// decay and no division takes the short path; the longest path adds decay, average update,
// ratio division and smoothing division, with three divider runs.
// The next transaction is accepted as soon as the sequencer is back in idle, even while
// the previous result still sits in the output register. When the receiver stalls, a
// finished sample waits before its final commit until the output register is free.
// Reset clears the sums, the timestamp history and the smoothed ratio, sets the running
// average to 838861 and window_ticks to 1000000; no clearing pass is needed.

module decayed_ratio_estimator #(
    parameter int DECAY_TABLE_ENTRIES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dre_pkg::SUM_W-1:0]     timestamp,
    input  logic [dre_pkg::VAL_W-1:0]     value_before,
    input  logic [dre_pkg::VAL_W-1:0]     value_after,
    input  logic                          constraint_applied,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dre_pkg::RATIO_W-1:0]   ratio_raw,
    output logic [dre_pkg::RATIO_W-1:0]   ratio_smoothed,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dre_pkg::*;

    op_t        op;
    status_t    status;
    logic       win_wr;
    logic [WIN_W-1:0] win_value;

    assign pready = 1'b1;
    assign win_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_TICKS);
    assign prdata = (paddr[2] == REG_WINDOW_TICKS) ? win_value : 32'h0;

    dre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op)
    );

    dre_datapath #(
        .DECAY_TABLE_ENTRIES (DECAY_TABLE_ENTRIES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .op                 (op),
        .status             (status),
        .win_wr             (win_wr),
        .win_data           (pwdata),
        .win_value          (win_value),
        .timestamp          (timestamp),
        .value_before       (value_before),
        .value_after        (value_after),
        .constraint_applied (constraint_applied),
        .ratio_raw          (ratio_raw),
        .ratio_smoothed     (ratio_smoothed)
    );

endmodule

// File: test/decayed_ratio_checker.sv
`timescale 1ns / 1ps

module decayed_ratio_checker #(
    parameter int TABLE_N = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [dre_pkg::SUM_W-1:0]      timestamp,
    input  logic [dre_pkg::VAL_W-1:0]      value_before,
    input  logic [dre_pkg::VAL_W-1:0]      value_after,
    input  logic                           constraint_applied,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [dre_pkg::RATIO_W-1:0]    ratio_raw,
    input  logic [dre_pkg::RATIO_W-1:0]    ratio_smoothed,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    output int                             mismatches,
    output int                             outstanding
);
    import dre_pkg::*;

    typedef struct packed {
        logic [RATIO_W-1:0] raw;
        logic [RATIO_W-1:0] smooth;
    } ratio_pair_t;

    logic [63:0] exp_lut [0:TABLE_N];

    logic [WIN_W-1:0]   window_reg;
    logic [63:0]        pred_acc;
    logic [63:0]        cons_acc;
    logic [63:0]        free_avg;
    logic [63:0]        last_ts;
    logic               have_last;
    logic [63:0]        smooth_acc;
    ratio_pair_t        ratio_queue[$];

    initial
    begin
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] r;
        a = (64'd16 << 32) / 64'(TABLE_N);
        term = 64'h1_0000_0000;
        r = 64'h1_0000_0000;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * a) >> 32) / 64'(n);
            if (n % 2 == 1)
                r = r - term;
            else
                r = r + term;
        end
        exp_lut[0] = 64'h1_0000_0000;
        for (int k = 1; k <= TABLE_N; k++)
            exp_lut[k] = (exp_lut[k-1] * r + 64'h8000_0000) >> 32;
    end

    function automatic logic [63:0] shrink(logic [63:0] s, logic [63:0] f);
        return ((s >> 24) * f + (((s & 64'hFF_FFFF) * f) >> 24)) >> 8;
    endfunction

    function automatic logic [63:0] sat48(logic [63:0] s);
        return (s > 64'(SUM_MAX)) ? 64'(SUM_MAX) : s;
    endfunction

    // Updates the running state with one sample and returns the ratios it produces.
    function automatic ratio_pair_t estimate_ratios(logic [63:0] ts, logic [63:0] vb,
                                                    logic [63:0] va, logic ca);
        logic [63:0] delta, win, dt, q, den, idx, frac, t0, t1, f, part, rat, a;
        ratio_pair_t res;
        delta = (va >= vb) ? va - vb : vb - va;
        win = (window_reg == 0) ? 64'd1 : 64'(window_reg);
        rat = 0;
        if (have_last && ts > last_ts)
        begin
            dt = ts - last_ts;
            q = dt * 64'(TABLE_N);
            den = 64'd16 * win;
            idx = q / den;
            if (idx >= 64'(TABLE_N))
                f = 0;
            else
            begin
                frac = ((q % den) << 16) / den;
                t0 = exp_lut[idx];
                t1 = exp_lut[idx + 1];
                f = t0 - (((t0 - t1) * frac) >> 16);
            end
            pred_acc = shrink(pred_acc, f);
            cons_acc = shrink(cons_acc, f);
        end
        if (delta != 0)
        begin
            if (ca)
            begin
                part = (delta < free_avg) ? delta : free_avg;
                pred_acc = sat48(pred_acc + part);
                cons_acc = sat48(cons_acc + delta - part);
            end
            else
            begin
                pred_acc = sat48(pred_acc + delta);
                free_avg = (64'd19 * free_avg + delta + 64'd10) / 64'd20;
            end
        end
        if (pred_acc != 0)
        begin
            if (cons_acc / pred_acc >= 64'd256)
                rat = 64'(RATIO_MAX);
            else
                rat = ((cons_acc / pred_acc) << 16) | (((cons_acc % pred_acc) << 16) / pred_acc);
        end
        if (last_ts == 0 || ts <= last_ts)
            smooth_acc = rat;
        else
        begin
            dt = ts - last_ts;
            if (dt < 64'd1000)
                dt = 64'd1000;
            if (dt >= win)
                smooth_acc = rat;
            else
            begin
                a = (dt << 32) / win;
                smooth_acc = (smooth_acc * (64'h1_0000_0000 - a) + rat * a
                              + 64'h8000_0000) >> 32;
            end
        end
        last_ts = ts;
        have_last = 1'b1;
        res.raw = rat[RATIO_W-1:0];
        res.smooth = smooth_acc[RATIO_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ratio_pair_t want;
        if (!rst_n)
        begin
            window_reg = WINDOW_RESET;
            pred_acc = 0;
            cons_acc = 0;
            free_avg = 64'(AVG_RESET);
            last_ts = 0;
            have_last = 1'b0;
            smooth_acc = 0;
            ratio_queue.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == 3'(REG_WINDOW_TICKS))
                window_reg = pwdata;
            if (in_valid && in_ready)
                ratio_queue.push_back(estimate_ratios(64'(timestamp), 64'(value_before),
                                                      64'(value_after), constraint_applied));
            if (out_valid && out_ready)
            begin
                if (ratio_queue.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result transaction: raw %h smoothed %h",
                                 ratio_raw, ratio_smoothed);
                    mismatches++;
                end
                else
                begin
                    want = ratio_queue.pop_front();
                    if (want.raw !== ratio_raw || want.smooth !== ratio_smoothed)
                    begin
                        if (mismatches < 10)
                            $display("ratio mismatch: raw exp %h got %h, smoothed exp %h got %h",
                                     want.raw, ratio_raw, want.smooth, ratio_smoothed);
                        mismatches++;
                    end
                end
            end
            outstanding = ratio_queue.size();
        end
    end

endmodule

// File: test/tb_decayed_ratio_estimator.sv
`timescale 1ns / 1ps

module tb_decayed_ratio_estimator;
    import dre_pkg::*;

    localparam int  RANDOM_SAMPLES = 1400;
    localparam int  CYCLE_LIMIT    = 2000000;
    localparam logic [63:0] TS_MAX = 64'hFFFF_FFFF_FFFF;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [SUM_W-1:0]    timestamp;
    logic [VAL_W-1:0]    value_before;
    logic [VAL_W-1:0]    value_after;
    logic                constraint_applied;
    logic                out_valid;
    logic                out_ready;
    logic [RATIO_W-1:0]  ratio_raw;
    logic [RATIO_W-1:0]  ratio_smoothed;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    int                  mismatches;
    int                  outstanding;
    int                  cycles;
    logic [63:0]         now_ts;
    logic [63:0]         eff_window;

    decayed_ratio_estimator DUT (.*);

    decayed_ratio_checker checker_inst (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_decayed_ratio_estimator: FAIL");
            $finish;
        end
    end

    // Receiver: alternates between free-running, choppy and long stall stretches.
    int stall_run;
    int ready_pct;
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_run <= $urandom_range(5, 80);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ready_pct <= 100;
                4:          ready_pct <= 0;
                default:    ready_pct <= $urandom_range(30, 90);
            endcase
        end
        else
            stall_run <= stall_run - 1;
        out_ready <= ($urandom_range(0, 99) < ready_pct);
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return 0;
        else if (k < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_sample(logic [63:0] ts, logic [31:0] vb, logic [31:0] va, logic ca);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        timestamp <= ts[SUM_W-1:0];
        value_before <= vb;
        value_after <= va;
        constraint_applied <= ca;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        in_valid <= 1'b0;
        // The checker updates its count at the rising edge, so it is read mid-cycle.
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (200) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if ((addr >> 2) == 3'(REG_WINDOW_TICKS))
            eff_window = (data == 0) ? 64'd1 : 64'(data);
    endtask

    // Next timestamp: mostly forward steps sized against the window, some stalls,
    // backward jumps and arbitrary values.
    function automatic logic [63:0] next_time(logic [63:0] ts, logic [63:0] w);
        logic [63:0] dt;
        case ($urandom_range(0, 11))
            0:       dt = 0;
            1:       dt = $urandom_range(1, 999);
            2, 3:    dt = (w * $urandom_range(0, 1023)) >> 10;
            4:       dt = w * $urandom_range(1, 20) + $urandom_range(0, 999);
            5:       return ts - (ts >> $urandom_range(0, 8));
            6:       return {$urandom, $urandom} & TS_MAX;
            default: dt = $urandom_range(1, 32'(w >> 3) + 1);
        endcase
        return (ts + dt > TS_MAX) ? TS_MAX : ts + dt;
    endfunction

    task automatic send_random();
        logic [31:0] vb;
        logic [31:0] d;
        now_ts = next_time(now_ts, eff_window);
        vb = $urandom;
        case ($urandom_range(0, 5))
            0:       d = 0;
            1:       d = $urandom_range(0, 65535);
            2:       d = $urandom_range(0, 2000000);
            3:       d = $urandom;
            default: d = $urandom_range(0, 1 << 24);
        endcase
        send_sample(now_ts, vb, $urandom_range(0, 1) ? vb + d : vb - d, $urandom_range(0, 1));
    endtask

    initial
    begin
        logic [31:0] windows [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        timestamp = '0;
        value_before = '0;
        value_after = '0;
        constraint_applied = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        now_ts = 0;
        eff_window = 64'(WINDOW_RESET);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero timestamps, extreme values, both flags, short dt, long gap,
        // time that stands still or runs backward, the last timestamp.
        send_sample(0, 0, 32'hFFFF_FFFF, 1'b0);
        send_sample(0, 32'hFFFF_FFFF, 0, 1'b1);
        send_sample(500, 100, 100, 1'b1);
        send_sample(900, 32'h0100_0000, 32'h0000_1000, 1'b1);
        send_sample(2000, 0, 32'h0200_0000, 1'b0);
        send_sample(2000, 32'h0200_0000, 0, 1'b1);
        send_sample(1500, 5, 32'hFFFF_FFFF, 1'b1);
        send_sample(400000, 0, 32'h1000, 1'b0);
        send_sample(900000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_sample(20000000, 0, 1000, 1'b1);
        send_sample(20000000 + 1000000 * 16, 0, 10, 1'b0);
        send_sample(TS_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        send_sample(TS_MAX, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        send_sample(3, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        now_ts = 3;
        write_reg(3'd4, 32'd77);

        windows[0] = 32'd0;
        windows[1] = 32'hFFFF_FFFF;
        windows[2] = 32'd5000;
        windows[3] = $urandom_range(1000, 2000000);
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
                write_reg(3'(4 * REG_WINDOW_TICKS), windows[phase-1]);
            for (int i = 0; i < RANDOM_SAMPLES / 5; i++)
                send_random();
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("tb_decayed_ratio_estimator: PASS");
        else
            $display("tb_decayed_ratio_estimator: FAIL");
        $finish;
    end

endmodule
